### sv/rectangle_overlap_merge_list_defines.svh
// assertion helpers for the rectangle list rtl, included by its top module
`ifndef RECTANGLE_OVERLAP_MERGE_LIST_DEFINES_SVH
`define RECTANGLE_OVERLAP_MERGE_LIST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ROLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ROLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rolm_pkg.sv
package rolm_pkg;

  localparam int FIELD_W = 16;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    ST_APPEND     = 2'd0,
    ST_MERGE      = 2'd1,
    ST_DROP_EMPTY = 2'd2,
    ST_DROP_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic                      start_list;
    logic signed [FIELD_W-1:0] rect_left;
    logic signed [FIELD_W-1:0] rect_top;
    logic signed [FIELD_W-1:0] rect_right;
    logic signed [FIELD_W-1:0] rect_bottom;
  } item_t;

  typedef struct packed {
    status_e                   status;
    logic [IDX_W-1:0]          entry_index;
    logic signed [FIELD_W-1:0] entry_left;
    logic signed [FIELD_W-1:0] entry_top;
    logic signed [FIELD_W-1:0] entry_right;
    logic signed [FIELD_W-1:0] entry_bottom;
    logic [CNT_W-1:0]          entry_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic append;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop_empty;
    logic scan_req;
    logic hit;
    logic last;
  } sts_t;

endpackage

### sv/rolm_ctrl.sv
module rolm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rolm_pkg::sts_t sts_i,
  output rolm_pkg::cmd_t cmd_o,
  output logic          busy
);
  import rolm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPEND
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start) state_q <= S_CHECK;
        end
        S_CHECK: begin
          priority if (sts_i.drop_empty) state_q <= S_IDLE;
          else if (sts_i.scan_req)       state_q <= S_SCAN;
          else                           state_q <= S_APPEND;
        end
        S_SCAN: begin
          priority if (sts_i.hit) state_q <= S_IDLE;
          else if (sts_i.last)    state_q <= S_APPEND;
          else                    state_q <= S_SCAN;
        end
        S_APPEND: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start;
    cmd_o.check  = (state_q == S_CHECK);
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.append = (state_q == S_APPEND);
  end

  assign busy = (state_q != S_IDLE);

endmodule

### sv/rolm_datapath.sv
module rolm_datapath #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rolm_pkg::item_t   item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  rolm_pkg::cmd_t    cmd_i,
  output rolm_pkg::sts_t    sts_o,
  output rolm_pkg::result_t result_o,
  output logic              done_o
);
  import rolm_pkg::*;

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int BW    = 4 * COORD_BITS;
  localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic coord_t coord_in(input logic [FIELD_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return $signed(ext[COORD_BITS-1:0]);
  endfunction

  // incoming rectangle
  coord_t nl_q, nt_q, nr_q, nb_q;

  logic [CW-1:0] count_q, count_d, cnt_inc;
  logic          merge_en_q;

  // scan pipeline: address issued, then the entry is compared in the following cycle
  logic [CW-1:0] rd_addr_q;
  logic [CW-1:0] cmp_idx_q;
  logic          cmp_vld_q;
  logic [BW-1:0] rdata_q;

  logic [BW-1:0] mem [MAX_ENTRIES];

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr;
  logic [BW-1:0] wr_data;

  coord_t  o_l, o_t, o_r, o_b;
  coord_t  u_l, u_t, u_r, u_b;
  logic    empty, overlap, full, hit, last;
  result_t res_d, result_q;
  logic    done_d, done_q;

  assign o_l = $signed(rdata_q[BW-1 -: COORD_BITS]);
  assign o_t = $signed(rdata_q[3*COORD_BITS-1 -: COORD_BITS]);
  assign o_r = $signed(rdata_q[2*COORD_BITS-1 -: COORD_BITS]);
  assign o_b = $signed(rdata_q[COORD_BITS-1:0]);

  assign empty   = (nr_q <= nl_q) || (nb_q <= nt_q);
  assign overlap = !((nr_q < o_l) || (nl_q > o_r) || (nb_q < o_t) || (nt_q > o_b));
  assign hit     = cmp_vld_q && overlap;
  assign last    = cmp_vld_q && (cmp_idx_q == (count_q - CW'(1)));
  assign full    = (count_q >= CW'(MAX_ENTRIES));
  assign cnt_inc = count_q + CW'(1);

  assign u_l = (o_l > nl_q) ? nl_q : o_l;
  assign u_t = (o_t > nt_q) ? nt_q : o_t;
  assign u_r = (o_r < nr_q) ? nr_q : o_r;
  assign u_b = (o_b < nb_q) ? nb_q : o_b;

  always_comb begin
    sts_o            = '0;
    sts_o.drop_empty = merge_en_q && empty;
    sts_o.scan_req   = merge_en_q && (count_q != '0);
    sts_o.hit        = hit;
    sts_o.last       = last;
  end

  assign wr_en   = (cmd_i.scan && hit) || (cmd_i.append && !full);
  assign wr_addr = cmd_i.scan ? cmp_idx_q[IW-1:0] : count_q[IW-1:0];
  assign wr_data = cmd_i.scan ? {u_l, u_t, u_r, u_b} : {nl_q, nt_q, nr_q, nb_q};
  assign rd_en   = cmd_i.scan && !hit;

  always_comb begin
    res_d  = '0;
    done_d = 1'b0;
    count_d = count_q;
    if (cmd_i.load && item_i.start_list) count_d = '0;
    if (cmd_i.check && sts_o.drop_empty) begin
      done_d            = 1'b1;
      res_d.status      = ST_DROP_EMPTY;
      res_d.entry_count = CNT_W'(count_q);
    end
    if (cmd_i.scan && hit) begin
      done_d             = 1'b1;
      res_d.status       = ST_MERGE;
      res_d.entry_index  = IDX_W'(cmp_idx_q);
      res_d.entry_left   = FIELD_W'(u_l);
      res_d.entry_top    = FIELD_W'(u_t);
      res_d.entry_right  = FIELD_W'(u_r);
      res_d.entry_bottom = FIELD_W'(u_b);
      res_d.entry_count  = CNT_W'(count_q);
    end
    if (cmd_i.append) begin
      done_d = 1'b1;
      if (full) begin
        res_d.status      = ST_DROP_FULL;
        res_d.entry_count = CNT_W'(count_q);
      end else begin
        res_d.status       = ST_APPEND;
        res_d.entry_index  = IDX_W'(count_q);
        res_d.entry_left   = FIELD_W'(nl_q);
        res_d.entry_top    = FIELD_W'(nt_q);
        res_d.entry_right  = FIELD_W'(nr_q);
        res_d.entry_bottom = FIELD_W'(nb_q);
        res_d.entry_count  = CNT_W'(cnt_inc);
        count_d            = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      merge_en_q <= 1'b1;
      rd_addr_q  <= '0;
      cmp_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) merge_en_q <= cfg_wdata_i;
      if (cmd_i.check) begin
        rd_addr_q <= '0;
        cmp_vld_q <= 1'b0;
      end else if (rd_en) begin
        rd_addr_q <= rd_addr_q + CW'(1);
        cmp_vld_q <= (rd_addr_q < count_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nl_q <= coord_in($unsigned(item_i.rect_left));
      nt_q <= coord_in($unsigned(item_i.rect_top));
      nr_q <= coord_in($unsigned(item_i.rect_right));
      nb_q <= coord_in($unsigned(item_i.rect_bottom));
    end
    if (rd_en) cmp_idx_q <= rd_addr_q;
    if (done_d) result_q <= res_d;
  end

  // rectangle store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr_q[IW-1:0]];
  end

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

### sv/rectangle_overlap_merge_list.sv
// rectangle list with overlap merging. each beat on item_i is taken when start is high and
// busy is low; it carries one rectangle and a start_list flag that empties the list first.
// exactly one result beat follows on result_o, marked by a one-cycle done_o strobe; the
// receiver cannot stall, so the result must be taken in that cycle. with merging on, an empty
// or inverted rectangle is dropped (status 2), otherwise the first stored entry that overlaps
// or touches it grows to the union box (status 1), else it is appended (status 0); a full list
// drops the append (status 3). each beat is checked; with merging on and a non-empty list the
// stored entries are then scanned one entry per cycle through the single read port of the
// rectangle store, and the rectangle is appended if no entry was hit. merge_enable is written
// through cfg_we_i/cfg_wdata_i and resets to 1; the user must write it only while the block is
// idle, which the block itself does not enforce. the store itself is never cleared: only
// entries below the current count are read.
`include "rectangle_overlap_merge_list_defines.svh"

module rectangle_overlap_merge_list #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rolm_pkg::item_t   item_i,
  output rolm_pkg::result_t result_o,
  output logic              done_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import rolm_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: check, scan, append steps
  rolm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // datapath: rectangle registers, store, compare and union, result register
  rolm_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .done_o      (done_o)
  );

  // an accepted beat keeps the block busy in the next cycle
  `ROLM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted beat not busy")
  // one result per beat: the strobe never repeats back to back
  `ROLM_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")
  // the result goes out only once the sequencer is back to idle
  `ROLM_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  // dropped rectangles report entry zero
  `ROLM_ASSERT_NOW(a_drop_index, clk_i, rst_ni, done_o && (result_o.status == ST_DROP_EMPTY || result_o.status == ST_DROP_FULL), result_o.entry_index == '0, "drop with nonzero index")

endmodule
